### design/efj_pkg.sv
// shared types, register codes and fixed-point helpers for the flux jacobian unit
`default_nettype none

package efj_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_GAMMA_M1   = 2'd0;
  localparam logic [1:0] CFG_GAMMA      = 2'd1;
  localparam logic [1:0] CFG_ENTH_COEF  = 2'd2;

  // reset values of the configuration registers
  localparam logic [30:0] GAMMA_M1_RST  = 31'd26214;
  localparam logic [30:0] GAMMA_RST     = 31'd91750;
  localparam logic [30:0] ENTH_COEF_RST = 31'd65830912;

  // row codes
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] qprod_t;

  typedef struct packed {
    q_t c0;
    q_t c1;
    q_t c2;
    q_t c3;
  } efj_row_t;

  typedef struct packed {
    q_t       ax;
    q_t       ay;
    efj_row_t r1;
    efj_row_t r2;
    efj_row_t r3;
    logic     done;
  } efj_point_t;

  typedef struct packed {
    q_t g;
    q_t gam;
    q_t ec;
  } efj_cfg_t;

  // full-width signed product
  function automatic qprod_t q_mul_raw(input q_t a, input q_t b);
    qprod_t p;
    p = a * b;
    return p;
  endfunction

  // drop 16 fraction bits (floor) and saturate to 32 bits
  function automatic q_t q_round(input qprod_t p);
    q_t r;
    if ((&p[63:47]) || !(|p[63:47])) begin
      r = p[47:16];
    end else if (p[63]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  function automatic q_t q_sat33(input logic signed [32:0] s);
    q_t r;
    if (s[32] != s[31]) begin
      r = s[32] ? Q_MIN : Q_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic q_t q_add(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return q_sat33(s);
  endfunction

  function automatic q_t q_sub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return q_sat33(s);
  endfunction

endpackage

`default_nettype wire

### design/efj_datapath.sv
// six-stage arithmetic pipeline producing rows one to three of the jacobian
`default_nettype none

module efj_datapath
  import efj_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire logic       in_valid,
  input  wire q_t         ax,
  input  wire q_t         ay,
  input  wire q_t         u,
  input  wire q_t         v,
  input  wire q_t         temp,
  input  wire logic       done,
  input  wire efj_cfg_t   cfg,
  output logic            pt_valid,
  output efj_point_t      pt
);

  // valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1: raw products of the inputs
  qprod_t s1_uu_r, s1_vv_r, s1_uax_r, s1_vay_r, s1_ect_r, s1_gu_r, s1_gv_r;
  qprod_t s1_axg_r, s1_ayg_r, s1_uay_r, s1_vax_r;
  q_t     s1_ax_r, s1_ay_r, s1_u_r, s1_v_r;
  logic   s1_done_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_uu_r   <= q_mul_raw(u, u);
      s1_vv_r   <= q_mul_raw(v, v);
      s1_uax_r  <= q_mul_raw(u, ax);
      s1_vay_r  <= q_mul_raw(v, ay);
      s1_ect_r  <= q_mul_raw(cfg.ec, temp);
      s1_gu_r   <= q_mul_raw(cfg.g, u);
      s1_gv_r   <= q_mul_raw(cfg.g, v);
      s1_axg_r  <= q_mul_raw(ax, cfg.g);
      s1_ayg_r  <= q_mul_raw(ay, cfg.g);
      s1_uay_r  <= q_mul_raw(u, ay);
      s1_vax_r  <= q_mul_raw(v, ax);
      s1_ax_r   <= ax;
      s1_ay_r   <= ay;
      s1_u_r    <= u;
      s1_v_r    <= v;
      s1_done_r <= done;
    end
  end

  // stage 2: round, squared-speed sum and normal velocity
  q_t   s2_suv_r, s2_qn_r, s2_uax_r, s2_vay_r, s2_ect_r, s2_gu_r, s2_gv_r;
  q_t   s2_axg_r, s2_ayg_r, s2_uay_r, s2_vax_r, s2_ax_r, s2_ay_r, s2_u_r, s2_v_r;
  logic s2_done_r;
  q_t   s2_uax_nxt, s2_vay_nxt;

  assign s2_uax_nxt = q_round(s1_uax_r);
  assign s2_vay_nxt = q_round(s1_vay_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_suv_r  <= q_add(q_round(s1_uu_r), q_round(s1_vv_r));
      s2_qn_r   <= q_add(s2_uax_nxt, s2_vay_nxt);
      s2_uax_r  <= s2_uax_nxt;
      s2_vay_r  <= s2_vay_nxt;
      s2_ect_r  <= q_round(s1_ect_r);
      s2_gu_r   <= q_round(s1_gu_r);
      s2_gv_r   <= q_round(s1_gv_r);
      s2_axg_r  <= q_round(s1_axg_r);
      s2_ayg_r  <= q_round(s1_ayg_r);
      s2_uay_r  <= q_round(s1_uay_r);
      s2_vax_r  <= q_round(s1_vax_r);
      s2_ax_r   <= s1_ax_r;
      s2_ay_r   <= s1_ay_r;
      s2_u_r    <= s1_u_r;
      s2_v_r    <= s1_v_r;
      s2_done_r <= s1_done_r;
    end
  end

  // stage 3: kinetic energy (half is a floor shift), enthalpy and second products
  q_t     s3_qq_nxt;
  qprod_t s3_axgqq_r, s3_aygqq_r, s3_gqq_r, s3_uqn_r, s3_vqn_r;
  qprod_t s3_guax_r, s3_guay_r, s3_gvax_r, s3_gvay_r, s3_gamqn_r, s3_guqn_r, s3_gvqn_r;
  q_t     s3_h_r, s3_qn_r, s3_uax_r, s3_vay_r, s3_uay_r, s3_vax_r;
  q_t     s3_axg_r, s3_ayg_r, s3_ax_r, s3_ay_r;
  logic   s3_done_r;

  assign s3_qq_nxt = s2_suv_r >>> 1;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_axgqq_r <= q_mul_raw(s2_axg_r, s3_qq_nxt);
      s3_aygqq_r <= q_mul_raw(s2_ayg_r, s3_qq_nxt);
      s3_gqq_r   <= q_mul_raw(cfg.g, s3_qq_nxt);
      s3_uqn_r   <= q_mul_raw(s2_u_r, s2_qn_r);
      s3_vqn_r   <= q_mul_raw(s2_v_r, s2_qn_r);
      s3_guax_r  <= q_mul_raw(s2_gu_r, s2_ax_r);
      s3_guay_r  <= q_mul_raw(s2_gu_r, s2_ay_r);
      s3_gvax_r  <= q_mul_raw(s2_gv_r, s2_ax_r);
      s3_gvay_r  <= q_mul_raw(s2_gv_r, s2_ay_r);
      s3_gamqn_r <= q_mul_raw(cfg.gam, s2_qn_r);
      s3_guqn_r  <= q_mul_raw(s2_gu_r, s2_qn_r);
      s3_gvqn_r  <= q_mul_raw(s2_gv_r, s2_qn_r);
      s3_h_r     <= q_add(s2_ect_r, s3_qq_nxt);
      s3_qn_r    <= s2_qn_r;
      s3_uax_r   <= s2_uax_r;
      s3_vay_r   <= s2_vay_r;
      s3_uay_r   <= s2_uay_r;
      s3_vax_r   <= s2_vax_r;
      s3_axg_r   <= s2_axg_r;
      s3_ayg_r   <= s2_ayg_r;
      s3_ax_r    <= s2_ax_r;
      s3_ay_r    <= s2_ay_r;
      s3_done_r  <= s2_done_r;
    end
  end

  // stage 4: rows one and two finish, energy difference for row three
  efj_row_t s4_r1_r, s4_r2_r, s4_r1_nxt, s4_r2_nxt;
  q_t       s4_d_r, s4_h_r, s4_qn_r, s4_guqn_r, s4_gvqn_r, s4_gamqn_r, s4_ax_r, s4_ay_r;
  logic     s4_done_r;

  always_comb begin
    s4_r1_nxt.c0 = q_sub(q_round(s3_axgqq_r), q_round(s3_uqn_r));
    s4_r1_nxt.c1 = q_add(q_sub(s3_uax_r, q_round(s3_guax_r)), s3_qn_r);
    s4_r1_nxt.c2 = q_sub(s3_uay_r, q_round(s3_gvax_r));
    s4_r1_nxt.c3 = s3_axg_r;
    s4_r2_nxt.c0 = q_sub(q_round(s3_aygqq_r), q_round(s3_vqn_r));
    s4_r2_nxt.c1 = q_sub(s3_vax_r, q_round(s3_guay_r));
    s4_r2_nxt.c2 = q_add(q_sub(s3_vay_r, q_round(s3_gvay_r)), s3_qn_r);
    s4_r2_nxt.c3 = s3_ayg_r;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_r1_r    <= s4_r1_nxt;
      s4_r2_r    <= s4_r2_nxt;
      s4_d_r     <= q_sub(q_round(s3_gqq_r), s3_h_r);
      s4_h_r     <= s3_h_r;
      s4_qn_r    <= s3_qn_r;
      s4_guqn_r  <= q_round(s3_guqn_r);
      s4_gvqn_r  <= q_round(s3_gvqn_r);
      s4_gamqn_r <= q_round(s3_gamqn_r);
      s4_ax_r    <= s3_ax_r;
      s4_ay_r    <= s3_ay_r;
      s4_done_r  <= s3_done_r;
    end
  end

  // stage 5: last products of row three
  qprod_t   s5_qnd_r, s5_axh_r, s5_ayh_r;
  efj_row_t s5_r1_r, s5_r2_r;
  q_t       s5_guqn_r, s5_gvqn_r, s5_gamqn_r, s5_ax_r, s5_ay_r;
  logic     s5_done_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_qnd_r   <= q_mul_raw(s4_qn_r, s4_d_r);
      s5_axh_r   <= q_mul_raw(s4_ax_r, s4_h_r);
      s5_ayh_r   <= q_mul_raw(s4_ay_r, s4_h_r);
      s5_r1_r    <= s4_r1_r;
      s5_r2_r    <= s4_r2_r;
      s5_guqn_r  <= s4_guqn_r;
      s5_gvqn_r  <= s4_gvqn_r;
      s5_gamqn_r <= s4_gamqn_r;
      s5_ax_r    <= s4_ax_r;
      s5_ay_r    <= s4_ay_r;
      s5_done_r  <= s4_done_r;
    end
  end

  // stage 6: row three finishes, whole point registered
  efj_point_t s6_pt_r, s6_pt_nxt;

  always_comb begin
    s6_pt_nxt.ax    = s5_ax_r;
    s6_pt_nxt.ay    = s5_ay_r;
    s6_pt_nxt.r1    = s5_r1_r;
    s6_pt_nxt.r2    = s5_r2_r;
    s6_pt_nxt.r3.c0 = q_round(s5_qnd_r);
    s6_pt_nxt.r3.c1 = q_sub(q_round(s5_axh_r), s5_guqn_r);
    s6_pt_nxt.r3.c2 = q_sub(q_round(s5_ayh_r), s5_gvqn_r);
    s6_pt_nxt.r3.c3 = s5_gamqn_r;
    s6_pt_nxt.done  = s5_done_r;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_pt_r <= s6_pt_nxt;
    end
  end

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign pt_valid = v6_r;
  assign pt       = s6_pt_r;

endmodule

`default_nettype wire

### design/euler_flux_jacobian_2d_unit.sv
// top level: configuration registers, arithmetic pipeline and four-row output sequencer
//
//   channel | ports                                                          | direction
//   --------+----------------------------------------------------------------+-----------
//   in      | in_valid/in_stall, metric, velocity, temperature, end_of_batch | request in
//   out     | out_valid/out_stall, row index, entries, last_row, batch_done  | request out
//   cfg     | cfg_we, cfg_index, cfg_wdata                                   | write only
//
// A point produces four row requests; the row sequencer takes a new point only as the
// last row of the current one is taken. Points enter on back-to-back cycles until the
// six-stage pipeline fills. The first row is shown once the point has left the pipeline
// and sits in the hold register. Synchronous reset clears the valid bits and restores
// the register defaults. A stall on the output holds the current row and freezes the
// whole pipeline once its last stage is waiting; nothing is dropped or repeated.
`default_nettype none

module euler_flux_jacobian_2d_unit
  import efj_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input requests
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_metric_x,
  input  wire logic [31:0] in_metric_y,
  input  wire logic [31:0] in_velocity_x,
  input  wire logic [31:0] in_velocity_y,
  input  wire logic [31:0] in_temperature,
  input  wire logic        in_end_of_batch,
  // result requests
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_row_index,
  output logic [31:0]      out_entry_0,
  output logic [31:0]      out_entry_1,
  output logic [31:0]      out_entry_2,
  output logic [31:0]      out_entry_3,
  output logic             out_last_row,
  output logic             out_batch_done,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata
);

  // configuration registers
  logic [30:0] gamma_m1_r, gamma_r, enth_coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_m1_r  <= GAMMA_M1_RST;
      gamma_r     <= GAMMA_RST;
      enth_coef_r <= ENTH_COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAMMA_M1:  gamma_m1_r  <= cfg_wdata;
        CFG_GAMMA:     gamma_r     <= cfg_wdata;
        CFG_ENTH_COEF: enth_coef_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  efj_cfg_t cfg;

  assign cfg.g   = $signed({1'b0, gamma_m1_r});
  assign cfg.gam = $signed({1'b0, gamma_r});
  assign cfg.ec  = $signed({1'b0, enth_coef_r});

  // pipeline and its hand-off to the sequencer
  logic       pt_valid;
  efj_point_t pt;
  logic       seq_ready;
  logic       advance;

  assign advance  = !pt_valid || seq_ready;
  assign in_stall = !advance;

  efj_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_valid),
    .ax       ($signed(in_metric_x)),
    .ay       ($signed(in_metric_y)),
    .u        ($signed(in_velocity_x)),
    .v        ($signed(in_velocity_y)),
    .temp     ($signed(in_temperature)),
    .done     (in_end_of_batch),
    .cfg      (cfg),
    .pt_valid (pt_valid),
    .pt       (pt)
  );

  // row sequencer holding one finished point
  logic       busy_r;
  logic [1:0] row_r;
  efj_point_t hold_r;
  logic       row_taken;

  assign row_taken = busy_r && !out_stall;
  assign seq_ready = !busy_r || (row_taken && row_r == ROW_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= ROW_FIRST;
    end else if (pt_valid && seq_ready) begin
      busy_r <= 1'b1;
      row_r  <= ROW_FIRST;
    end else if (row_taken) begin
      busy_r <= (row_r != ROW_LAST);
      row_r  <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_valid && seq_ready) begin
      hold_r <= pt;
    end
  end

  // row select onto the result ports
  efj_row_t row_sel;

  always_comb begin
    unique case (row_r)
      2'd0: begin
        row_sel.c0 = '0;
        row_sel.c1 = hold_r.ax;
        row_sel.c2 = hold_r.ay;
        row_sel.c3 = '0;
      end
      2'd1:    row_sel = hold_r.r1;
      2'd2:    row_sel = hold_r.r2;
      default: row_sel = hold_r.r3;
    endcase
  end

  assign out_valid      = busy_r;
  assign out_row_index  = row_r;
  assign out_entry_0    = row_sel.c0;
  assign out_entry_1    = row_sel.c1;
  assign out_entry_2    = row_sel.c2;
  assign out_entry_3    = row_sel.c3;
  assign out_last_row   = (row_r == ROW_LAST);
  assign out_batch_done = out_last_row && hold_r.done;

`ifndef NO_ASSERTIONS
  // rows of a point come out in order
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_row |=>
      out_valid && out_row_index == 2'($past(out_row_index) + 2'd1))
    else $error("row sequence broken");

  // a new point always starts at the first row
  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    pt_valid && seq_ready |=> out_valid && out_row_index == ROW_FIRST)
    else $error("point did not start at the first row");

  // sequencer empties after the last row when nothing waits
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_row && !pt_valid |=> !out_valid)
    else $error("sequencer did not empty");

  // a waiting point is held while the sequencer is busy
  a_pt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pt_valid && !seq_ready |=> pt_valid && $stable(pt))
    else $error("waiting point changed");

  // batch flag only on the last row
  a_batch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_batch_done |-> out_last_row)
    else $error("batch flag off the last row");
`endif

endmodule

`default_nettype wire
